// ===== rtl/core/infix_expression_evaluator_unit_macros.svh =====
// Assertion macros for the infix expression evaluator.
// Depends on nothing; included by the files that carry assertions.
`ifndef INFIX_EXPRESSION_EVALUATOR_UNIT_MACROS_SVH
`define INFIX_EXPRESSION_EVALUATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IEE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IEE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/iee_pkg.sv =====
// Shared types, codes and the microcode ROM of the infix expression evaluator.
// Depends on nothing; used by iee_seq and the top level of the block.
package iee_pkg;

    // Token actions
    localparam logic [2:0] ACT_OPERAND  = 3'd0;
    localparam logic [2:0] ACT_OPERATOR = 3'd1;
    localparam logic [2:0] ACT_OPEN     = 3'd2;
    localparam logic [2:0] ACT_CLOSE    = 3'd3;
    localparam logic [2:0] ACT_END      = 3'd4;

    // Operator codes; the open-paren marker sits on the operator stack too
    localparam logic [2:0] OP_MUL   = 3'd0;
    localparam logic [2:0] OP_DIV   = 3'd1;
    localparam logic [2:0] OP_SUB   = 3'd2;
    localparam logic [2:0] OP_ADD   = 3'd3;
    localparam logic [2:0] OP_AND   = 3'd4;
    localparam logic [2:0] OP_XOR   = 3'd5;
    localparam logic [2:0] OP_OR    = 3'd6;
    localparam logic [2:0] OP_PAREN = 3'd7;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_MALFORMED = 2'd3;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] operand_value;
        logic [2:0]         operator_code;
    } t_token;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
    } t_result;

    // Datapath micro-operations
    typedef enum logic [3:0] {
        U_NOP,
        U_FLAG_BAD,
        U_PUSH_VAL,
        U_PUSH_PAREN,
        U_PUSH_OPR,
        U_POP_OPR,
        U_REDUCE_POP,
        U_EXEC,
        U_PUSH_RES,
        U_EMIT
    } t_uop;

    // Sequencer branch conditions
    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_ERR,
        C_EXP,
        C_NEXP,
        C_CODE_BAD,
        C_NOT_PREC,
        C_NOT_TOPOP,
        C_OPR_EMPTY,
        C_TOP_PAREN,
        C_OUT_BUSY,
        C_DIV_BUSY,
        C_CALL,
        C_RET,
        C_DISPATCH
    } t_cond;

    localparam int USTEP_W = 6;
    typedef logic [USTEP_W-1:0] t_ustep;

    typedef struct packed {
        t_uop   uop;
        t_cond  cond;
        t_ustep target;
    } t_uword;

    // Status bits the datapath hands to the sequencer
    typedef struct packed {
        logic err;
        logic want_opd;
        logic code_bad;
        logic not_prec;
        logic not_topop;
        logic opr_empty;
        logic top_paren;
        logic out_busy;
        logic div_busy;
    } t_uflags;

    // Microcode addresses
    localparam t_ustep S_WAIT      = 6'd0;
    localparam t_ustep S_BAD       = 6'd1;
    localparam t_ustep S_OPD       = 6'd2;
    localparam t_ustep S_OPD_PUSH  = 6'd3;
    localparam t_ustep S_OPEN      = 6'd4;
    localparam t_ustep S_OPEN_PUSH = 6'd5;
    localparam t_ustep S_OPR       = 6'd6;
    localparam t_ustep S_OPR_CODE  = 6'd7;
    localparam t_ustep S_OPR_LOOP  = 6'd8;
    localparam t_ustep S_OPR_CALL  = 6'd9;
    localparam t_ustep S_OPR_ERR   = 6'd10;
    localparam t_ustep S_OPR_BACK  = 6'd11;
    localparam t_ustep S_OPR_PUSH  = 6'd12;
    localparam t_ustep S_CLOSE     = 6'd13;
    localparam t_ustep S_CL_LOOP   = 6'd14;
    localparam t_ustep S_CL_CALL   = 6'd15;
    localparam t_ustep S_CL_ERR    = 6'd16;
    localparam t_ustep S_CL_BACK   = 6'd17;
    localparam t_ustep S_CL_POP    = 6'd18;
    localparam t_ustep S_CL_DROP   = 6'd19;
    localparam t_ustep S_END       = 6'd20;
    localparam t_ustep S_END_FLAG  = 6'd21;
    localparam t_ustep S_END_LOOP  = 6'd22;
    localparam t_ustep S_END_EMPTY = 6'd23;
    localparam t_ustep S_END_PAREN = 6'd24;
    localparam t_ustep S_END_CALL  = 6'd25;
    localparam t_ustep S_END_BACK  = 6'd26;
    localparam t_ustep S_END_BAD   = 6'd27;
    localparam t_ustep S_END_OUT   = 6'd28;
    localparam t_ustep S_END_EMIT  = 6'd29;
    localparam t_ustep S_RED       = 6'd30;
    localparam t_ustep S_RED_CHK   = 6'd31;
    localparam t_ustep S_RED_EXEC  = 6'd32;
    localparam t_ustep S_RED_WAIT  = 6'd33;
    localparam t_ustep S_RED_PUSH  = 6'd34;
    localparam t_ustep S_RED_RET   = 6'd35;

    function automatic t_uword uw(t_uop u, t_cond c, t_ustep t);
        t_uword w;
        w.uop    = u;
        w.cond   = c;
        w.target = t;
        return w;
    endfunction

    // Microcode ROM: one control word per step
    function automatic t_uword ucode(t_ustep step);
        t_uword w;
        unique case (step)
            S_WAIT:      w = uw(U_NOP,        C_DISPATCH,  S_WAIT);
            S_BAD:       w = uw(U_FLAG_BAD,   C_ALWAYS,    S_WAIT);
            // operand
            S_OPD:       w = uw(U_NOP,        C_NEXP,      S_BAD);
            S_OPD_PUSH:  w = uw(U_PUSH_VAL,   C_ALWAYS,    S_WAIT);
            // open paren
            S_OPEN:      w = uw(U_NOP,        C_NEXP,      S_BAD);
            S_OPEN_PUSH: w = uw(U_PUSH_PAREN, C_ALWAYS,    S_WAIT);
            // operator: reduce while stacked level is equal or tighter
            S_OPR:       w = uw(U_NOP,        C_EXP,       S_BAD);
            S_OPR_CODE:  w = uw(U_NOP,        C_CODE_BAD,  S_BAD);
            S_OPR_LOOP:  w = uw(U_NOP,        C_NOT_PREC,  S_OPR_PUSH);
            S_OPR_CALL:  w = uw(U_NOP,        C_CALL,      S_RED);
            S_OPR_ERR:   w = uw(U_NOP,        C_ERR,       S_WAIT);
            S_OPR_BACK:  w = uw(U_NOP,        C_ALWAYS,    S_OPR_LOOP);
            S_OPR_PUSH:  w = uw(U_PUSH_OPR,   C_ALWAYS,    S_WAIT);
            // close paren: reduce down to the marker, then drop it
            S_CLOSE:     w = uw(U_NOP,        C_EXP,       S_BAD);
            S_CL_LOOP:   w = uw(U_NOP,        C_NOT_TOPOP, S_CL_POP);
            S_CL_CALL:   w = uw(U_NOP,        C_CALL,      S_RED);
            S_CL_ERR:    w = uw(U_NOP,        C_ERR,       S_WAIT);
            S_CL_BACK:   w = uw(U_NOP,        C_ALWAYS,    S_CL_LOOP);
            S_CL_POP:    w = uw(U_NOP,        C_OPR_EMPTY, S_BAD);
            S_CL_DROP:   w = uw(U_POP_OPR,    C_ALWAYS,    S_WAIT);
            // end: reduce everything, then emit
            S_END:       w = uw(U_NOP,        C_NEXP,      S_END_LOOP);
            S_END_FLAG:  w = uw(U_FLAG_BAD,   C_NONE,      S_WAIT);
            S_END_LOOP:  w = uw(U_NOP,        C_ERR,       S_END_OUT);
            S_END_EMPTY: w = uw(U_NOP,        C_OPR_EMPTY, S_END_OUT);
            S_END_PAREN: w = uw(U_NOP,        C_TOP_PAREN, S_END_BAD);
            S_END_CALL:  w = uw(U_NOP,        C_CALL,      S_RED);
            S_END_BACK:  w = uw(U_NOP,        C_ALWAYS,    S_END_LOOP);
            S_END_BAD:   w = uw(U_FLAG_BAD,   C_NONE,      S_WAIT);
            S_END_OUT:   w = uw(U_NOP,        C_OUT_BUSY,  S_END_OUT);
            S_END_EMIT:  w = uw(U_EMIT,       C_ALWAYS,    S_WAIT);
            // reduce subroutine: pop operator and two operands, push result
            S_RED:       w = uw(U_REDUCE_POP, C_NONE,      S_WAIT);
            S_RED_CHK:   w = uw(U_NOP,        C_ERR,       S_RED_RET);
            S_RED_EXEC:  w = uw(U_EXEC,       C_NONE,      S_WAIT);
            S_RED_WAIT:  w = uw(U_NOP,        C_DIV_BUSY,  S_RED_WAIT);
            S_RED_PUSH:  w = uw(U_PUSH_RES,   C_NONE,      S_WAIT);
            S_RED_RET:   w = uw(U_NOP,        C_RET,       S_WAIT);
            default:     w = uw(U_NOP,        C_ALWAYS,    S_WAIT);
        endcase
        return w;
    endfunction

    // Binding strength, larger is tighter
    function automatic logic [2:0] op_level(logic [2:0] op);
        logic [2:0] lv;
        case (op)
            OP_MUL, OP_DIV: lv = 3'd4;
            OP_SUB, OP_ADD: lv = 3'd3;
            OP_AND:         lv = 3'd2;
            OP_XOR:         lv = 3'd1;
            default:        lv = 3'd0;
        endcase
        return lv;
    endfunction

endpackage

// ===== rtl/core/iee_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
// Depends on nothing; the payload type is set per instance.
interface iee_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/iee_div.sv =====
// Signed 32-bit divider, truncating toward zero, one quotient bit per cycle.
// Depends on nothing outside this file.
module iee_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic [31:0] o_quotient
);
    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_den;
    logic        r_neg;
    logic [32:0] shifted;
    logic [32:0] diff;

    // one restoring step
    assign shifted = {r_rem, r_quo[31]};
    assign diff    = shifted - {1'b0, r_den};

    // busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == 5'd0) begin
            r_busy <= 1'b0;
        end
    end

    // magnitudes at start, then shift/subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
            r_den <= i_divisor[31] ? (32'd0 - i_divisor) : i_divisor;
            r_neg <= i_dividend[31] ^ i_divisor[31];
            r_rem <= 32'd0;
            r_cnt <= 5'd31;
        end else if (r_busy) begin
            if (!diff[32]) begin
                r_rem <= diff[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= shifted[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
            r_cnt <= r_cnt - 5'd1;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_neg ? (32'd0 - r_quo) : r_quo;
endmodule

// ===== rtl/core/iee_seq.sv =====
// Microcode sequencer: step counter, return register and branch logic.
// Depends on iee_pkg for the control word, flags and the microcode ROM.
module iee_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  iee_pkg::t_uflags i_flags,
    input  logic             i_take,
    input  logic [2:0]       i_action,
    output iee_pkg::t_uword  o_uword,
    output logic             o_idle
);
    import iee_pkg::*;

    t_ustep r_step;
    t_ustep n_step;
    t_ustep r_ret;
    t_ustep n_ret;
    t_ustep step_inc;
    t_uword word;

    // entry point for an accepted item; after an error only end is handled
    function automatic t_ustep dispatch(logic [2:0] act, logic err);
        t_ustep s;
        if (err && act != ACT_END) begin
            s = S_WAIT;
        end else begin
            case (act)
                ACT_OPERAND:  s = S_OPD;
                ACT_OPERATOR: s = S_OPR;
                ACT_OPEN:     s = S_OPEN;
                ACT_CLOSE:    s = S_CLOSE;
                ACT_END:      s = S_END;
                default:      s = S_BAD;
            endcase
        end
        return s;
    endfunction

    assign word     = ucode(r_step);
    assign step_inc = r_step + t_ustep'(1);

    // next step
    always_comb begin
        n_step = step_inc;
        n_ret  = r_ret;
        unique case (word.cond)
            C_NONE:      n_step = step_inc;
            C_ALWAYS:    n_step = word.target;
            C_ERR:       if (i_flags.err)       n_step = word.target;
            C_EXP:       if (i_flags.want_opd)  n_step = word.target;
            C_NEXP:      if (!i_flags.want_opd) n_step = word.target;
            C_CODE_BAD:  if (i_flags.code_bad)  n_step = word.target;
            C_NOT_PREC:  if (i_flags.not_prec)  n_step = word.target;
            C_NOT_TOPOP: if (i_flags.not_topop) n_step = word.target;
            C_OPR_EMPTY: if (i_flags.opr_empty) n_step = word.target;
            C_TOP_PAREN: if (i_flags.top_paren) n_step = word.target;
            C_OUT_BUSY:  if (i_flags.out_busy)  n_step = word.target;
            C_DIV_BUSY:  if (i_flags.div_busy)  n_step = word.target;
            C_CALL: begin
                n_step = word.target;
                n_ret  = step_inc;
            end
            C_RET:       n_step = r_ret;
            C_DISPATCH:  n_step = i_take ? dispatch(i_action, i_flags.err) : r_step;
            default:     n_step = S_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_WAIT;
            r_ret  <= S_WAIT;
        end else begin
            r_step <= n_step;
            r_ret  <= n_ret;
        end
    end

    assign o_uword = word;
    assign o_idle  = (word.cond == C_DISPATCH);
endmodule

// ===== rtl/core/infix_expression_evaluator_unit.sv =====
// Top level of the infix expression evaluator: stacks, ALU and output register.
// Depends on iee_pkg, iee_stream_if, iee_seq, iee_div and the macros header.
//
// Usage: tokens enter on i_tok (iee_stream_if carrying iee_pkg::t_token):
// operand, operator, open paren, close paren or end. Only end yields an
// item on o_res (iee_stream_if carrying iee_pkg::t_result): the value and
// a status (ok, division by zero, stack overflow, malformed order).
// A microcode sequencer runs a short program per token; i_tok.ready is
// high only while it waits for the next token.
// Each token runs its program to the end before the next is taken; an
// operator or close paren reduces stacked operators first, a divide
// waiting on the divider. End reduces all that is stacked (skipping this
// once an error is flagged), then raises o_res.valid and waits again.
// The divider is the long pole: one quotient bit per cycle.
// Reset (synchronous, active low) empties both stacks and clears the
// error; stack contents are not cleared and need no clearing pass.
// A stalled result holds in the output register; the block keeps taking
// tokens and only waits at the next end until that result has gone.
`include "infix_expression_evaluator_unit_macros.svh"

module infix_expression_evaluator_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    iee_stream_if.sink   i_tok,
    iee_stream_if.source o_res
);
    import iee_pkg::*;

    localparam int TOP_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    // sequencer
    t_uword  uw;
    t_uflags flags;
    logic    seq_idle;
    logic    take;

    // token latch
    logic [31:0] r_val;
    logic [2:0]  r_code;

    // stack control state
    logic [TOP_W-1:0] r_opr_top, n_opr_top;
    logic [TOP_W-1:0] r_opd_top, n_opd_top;
    logic             r_expect, n_expect;
    logic [1:0]       r_err, n_err;
    logic [1:0]       flag;

    // stack memories and their registered read data
    logic [2:0]  opr_mem [STACK_DEPTH];
    logic [31:0] opd_mem [STACK_DEPTH];
    logic [2:0]  r_op_rd;
    logic [31:0] r_opd_a;
    logic [31:0] r_opd_b;
    logic              opr_we, opd_we;
    logic [2:0]        opr_wd;
    logic [31:0]       opd_wd;
    logic [TOP_W-1:0]  opr_dec, opd_dec1, opd_dec2;
    logic              opr_full, opd_full, opd_lt2;

    // reduce operands and ALU
    logic [2:0]  r_aop, n_aop;
    logic [31:0] r_lhs, n_lhs;
    logic [31:0] r_rhs, n_rhs;
    logic [31:0] r_res, n_res;
    logic [31:0] prod_lo;
    logic        div_start;
    logic        div_busy;
    logic [31:0] div_quo;
    logic        top_is_op;

    // output register
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_val, n_out_val;
    logic [1:0]  r_out_status, n_out_status;

    iee_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_flags  (flags),
        .i_take   (take),
        .i_action (i_tok.payload.action),
        .o_uword  (uw),
        .o_idle   (seq_idle)
    );

    iee_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_lhs),
        .i_divisor  (r_rhs),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    assign i_tok.ready = seq_idle;
    assign take        = i_tok.valid && seq_idle;

    // stack pointers and status
    assign opr_dec   = r_opr_top - TOP_W'(1);
    assign opd_dec1  = r_opd_top - TOP_W'(1);
    assign opd_dec2  = r_opd_top - TOP_W'(2);
    assign opr_full  = (r_opr_top == TOP_W'(STACK_DEPTH));
    assign opd_full  = (r_opd_top == TOP_W'(STACK_DEPTH));
    assign opd_lt2   = (r_opd_top < TOP_W'(2));
    assign top_is_op = (r_opr_top != '0) && (r_op_rd != OP_PAREN);

    // flags for the sequencer
    always_comb begin
        flags.err       = (r_err != ST_OK);
        flags.want_opd  = r_expect;
        flags.code_bad  = (r_code > OP_OR);
        flags.not_prec  = !(top_is_op && (op_level(r_op_rd) >= op_level(r_code)));
        flags.not_topop = !top_is_op;
        flags.opr_empty = (r_opr_top == '0);
        flags.top_paren = (r_op_rd == OP_PAREN);
        flags.out_busy  = r_out_valid;
        flags.div_busy  = div_busy;
    end

    assign prod_lo = r_lhs * r_rhs;

    // datapath action per micro-op
    always_comb begin
        n_opr_top    = r_opr_top;
        n_opd_top    = r_opd_top;
        n_expect     = r_expect;
        n_err        = r_err;
        flag         = ST_OK;
        opr_we       = 1'b0;
        opr_wd       = r_code;
        opd_we       = 1'b0;
        opd_wd       = r_val;
        n_aop        = r_aop;
        n_lhs        = r_lhs;
        n_rhs        = r_rhs;
        n_res        = r_res;
        div_start    = 1'b0;
        n_out_valid  = r_out_valid;
        n_out_val    = r_out_val;
        n_out_status = r_out_status;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (uw.uop)
            U_NOP: ;
            U_FLAG_BAD: flag = ST_MALFORMED;
            U_PUSH_VAL: begin
                if (opd_full) begin
                    flag = ST_OVERFLOW;
                end else begin
                    opd_we    = 1'b1;
                    opd_wd    = r_val;
                    n_opd_top = r_opd_top + TOP_W'(1);
                end
                n_expect = 1'b0;
            end
            U_PUSH_PAREN: begin
                if (opr_full) begin
                    flag = ST_OVERFLOW;
                end else begin
                    opr_we    = 1'b1;
                    opr_wd    = OP_PAREN;
                    n_opr_top = r_opr_top + TOP_W'(1);
                end
            end
            U_PUSH_OPR: begin
                if (opr_full) begin
                    flag = ST_OVERFLOW;
                end else begin
                    opr_we    = 1'b1;
                    opr_wd    = r_code;
                    n_opr_top = r_opr_top + TOP_W'(1);
                end
                n_expect = 1'b1;
            end
            U_POP_OPR: n_opr_top = opr_dec;
            U_REDUCE_POP: begin
                // top operand is the right-hand side
                n_opr_top = opr_dec;
                n_aop     = r_op_rd;
                n_lhs     = r_opd_b;
                n_rhs     = r_opd_a;
                if (opd_lt2) begin
                    flag = ST_MALFORMED;
                end else begin
                    n_opd_top = opd_dec2;
                end
            end
            U_EXEC: begin
                case (r_aop)
                    OP_MUL: n_res = prod_lo;
                    OP_DIV: begin
                        if (r_rhs == 32'd0) begin
                            flag = ST_DIV_ZERO;
                        end else begin
                            div_start = 1'b1;
                        end
                    end
                    OP_SUB:  n_res = r_lhs - r_rhs;
                    OP_ADD:  n_res = r_lhs + r_rhs;
                    OP_AND:  n_res = r_lhs & r_rhs;
                    OP_XOR:  n_res = r_lhs ^ r_rhs;
                    default: n_res = r_lhs | r_rhs;
                endcase
            end
            U_PUSH_RES: begin
                if (opd_full) begin
                    flag = ST_OVERFLOW;
                end else begin
                    opd_we    = 1'b1;
                    opd_wd    = (r_aop == OP_DIV) ? div_quo : r_res;
                    n_opd_top = r_opd_top + TOP_W'(1);
                end
            end
            U_EMIT: begin
                // exactly one value must remain
                if (r_err != ST_OK) begin
                    n_out_status = r_err;
                end else if (r_opd_top != TOP_W'(1)) begin
                    n_out_status = ST_MALFORMED;
                end else begin
                    n_out_status = ST_OK;
                end
                n_out_val   = (n_out_status == ST_OK) ? r_opd_a : 32'd0;
                n_out_valid = 1'b1;
                n_opr_top   = '0;
                n_opd_top   = '0;
                n_expect    = 1'b1;
                n_err       = ST_OK;
            end
            default: ;
        endcase

        // first error wins
        if (r_err == ST_OK && flag != ST_OK) begin
            n_err = flag;
        end
    end

    // stack memories, read at the top every cycle
    always_ff @(posedge i_clk) begin
        if (opr_we) begin
            opr_mem[r_opr_top[ADDR_W-1:0]] <= opr_wd;
        end
        r_op_rd <= opr_mem[opr_dec[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (opd_we) begin
            opd_mem[r_opd_top[ADDR_W-1:0]] <= opd_wd;
        end
        r_opd_a <= opd_mem[opd_dec1[ADDR_W-1:0]];
        r_opd_b <= opd_mem[opd_dec2[ADDR_W-1:0]];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opr_top   <= '0;
            r_opd_top   <= '0;
            r_expect    <= 1'b1;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_opr_top   <= n_opr_top;
            r_opd_top   <= n_opd_top;
            r_expect    <= n_expect;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_val  <= i_tok.payload.operand_value;
            r_code <= i_tok.payload.operator_code;
        end
        r_aop        <= n_aop;
        r_lhs        <= n_lhs;
        r_rhs        <= n_rhs;
        r_res        <= n_res;
        r_out_val    <= n_out_val;
        r_out_status <= n_out_status;
    end

    assign o_res.valid                = r_out_valid;
    assign o_res.payload.result_value = r_out_val;
    assign o_res.payload.status       = r_out_status;

    // checks
    `IEE_ASSERT_NOW(a_ready_div_idle, i_clk, i_rst_n, i_tok.ready, !div_busy, "token taken while divider busy")
    `IEE_ASSERT_NOW(a_tops_in_range, i_clk, i_rst_n, 1'b1, (r_opr_top <= TOP_W'(STACK_DEPTH)) && (r_opd_top <= TOP_W'(STACK_DEPTH)), "stack pointer past depth")
    `IEE_ASSERT_NEXT(a_emit_clears, i_clk, i_rst_n, uw.uop == U_EMIT, (r_opr_top == '0) && (r_opd_top == '0) && r_expect && (r_err == ST_OK) && r_out_valid, "end of expression did not clear state")
    `IEE_ASSERT_NOW(a_div_nonzero, i_clk, i_rst_n, div_start, r_rhs != 32'd0, "divider started with zero divisor")
endmodule
